[sv/uart_pkg.sv]
package uart_pkg;

   localparam int PERIOD_W  = 20;
   localparam int TIMEOUT_W = 16;
   localparam int ELAPSED_W = 26;
   localparam int DATA_W    = 8;
   localparam int STATUS_W  = 2;

   localparam logic [PERIOD_W-1:0]  PERIOD_RESET = PERIOD_W'(104);
   localparam logic [PERIOD_W-1:0]  PERIOD_MIN   = PERIOD_W'(8);
   localparam logic [ELAPSED_W-1:0] US_PER_MS    = ELAPSED_W'(1000);

   localparam logic [STATUS_W-1:0] RX_STATUS_BYTE    = 2'd0;
   localparam logic [STATUS_W-1:0] RX_STATUS_TIMEOUT = 2'd1;
   localparam logic [STATUS_W-1:0] RX_STATUS_FALSE   = 2'd2;

   typedef struct packed {
      logic                busy;
      logic                done;
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   data;
   } rx_result_type;

endpackage

[sv/uart_tx_core.sv]
module uart_tx_core
   import uart_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic                start,
   input  logic [DATA_W-1:0]   data,
   input  logic [PERIOD_W-1:0] period,
   output logic                tx_line,
   output logic                tx_busy
);

   logic                active_ff, active_in;
   logic [3:0]          count_ff, count_in;
   logic [DATA_W-1:0]   shift_ff, shift_in;
   logic [PERIOD_W-1:0] timer_ff, timer_in;

   logic                start_now;
   logic                active;
   logic [3:0]          count;
   logic [DATA_W-1:0]   shift;
   logic [PERIOD_W-1:0] timer;
   logic [PERIOD_W:0]   timer_inc;

   always_comb begin
      start_now = !active_ff && start;
      active    = active_ff || start_now;
      count     = start_now ? 4'd0 : count_ff;
      shift     = start_now ? data : shift_ff;
      timer     = start_now ? '0 : timer_ff;
      timer_inc = {1'b0, timer} + (PERIOD_W+1)'(1);

      // Start bit low, eight data bits, then the high stop bit.
      if (!active) begin
         tx_line = 1'b1;
      end else if (count == 4'd0) begin
         tx_line = 1'b0;
      end else if (count <= 4'd8) begin
         tx_line = shift[0];
      end else begin
         tx_line = 1'b1;
      end
      tx_busy = active;

      active_in = active;
      count_in  = count;
      shift_in  = shift;
      timer_in  = timer;
      if (active) begin
         if (timer_inc >= {1'b0, period}) begin
            timer_in = '0;
            if (count >= 4'd1 && count <= 4'd8) begin
               shift_in = shift >> 1;
            end
            if (count >= 4'd9) begin
               active_in = 1'b0;
               count_in  = 4'd0;
            end else begin
               count_in = count + 4'd1;
            end
         end else begin
            timer_in = timer_inc[PERIOD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         count_ff  <= 4'd0;
         shift_ff  <= '0;
         timer_ff  <= '0;
      end else if (step) begin
         active_ff <= active_in;
         count_ff  <= count_in;
         shift_ff  <= shift_in;
         timer_ff  <= timer_in;
      end
   end

endmodule

[sv/uart_rx_core.sv]
module uart_rx_core
   import uart_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 line,
   input  logic                 arm,
   input  logic [TIMEOUT_W-1:0] limit_ms,
   input  logic [PERIOD_W-1:0]  period,
   output rx_result_type        result
);

   localparam logic [2:0] PH_IDLE      = 3'd0;
   localparam logic [2:0] PH_WAIT_HIGH = 3'd1;
   localparam logic [2:0] PH_WAIT_LOW  = 3'd2;
   localparam logic [2:0] PH_START     = 3'd3;
   localparam logic [2:0] PH_DATA      = 3'd4;
   localparam logic [2:0] PH_STOP      = 3'd5;

   logic [2:0]           phase_ff, phase_in;
   logic [PERIOD_W-1:0]  timer_ff, timer_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [ELAPSED_W-1:0] limit_ff, limit_in;
   logic [DATA_W-1:0]    shift_ff, shift_in;
   logic [3:0]           count_ff, count_in;

   logic                 arm_now;
   logic [2:0]           phase;
   logic [ELAPSED_W-1:0] elapsed;
   logic [ELAPSED_W-1:0] elapsed_inc;
   logic                 no_limit;
   logic                 limit_hit;
   logic [PERIOD_W:0]    timer_inc;
   logic [PERIOD_W:0]    half_period;
   logic [3:0]           count_inc;

   always_comb begin
      arm_now     = (phase_ff == PH_IDLE) && arm;
      phase       = arm_now ? PH_WAIT_HIGH : phase_ff;
      elapsed     = arm_now ? '0 : elapsed_ff;
      elapsed_inc = elapsed + ELAPSED_W'(1);
      // The limit in microseconds is registered at arm time. On the arm tick
      // the count is only 1, which never reaches a nonzero limit.
      limit_in    = arm_now ? ELAPSED_W'(limit_ms) * US_PER_MS : limit_ff;
      no_limit    = arm_now ? (limit_ms == '0) : (limit_ff == '0);
      limit_hit   = !arm_now && (elapsed_inc >= limit_ff);
      timer_inc   = {1'b0, timer_ff} + (PERIOD_W+1)'(1);
      half_period = {2'b00, period[PERIOD_W-1:1]};
      count_inc   = count_ff + 4'd1;

      phase_in      = phase;
      timer_in      = timer_ff;
      elapsed_in    = elapsed;
      shift_in      = shift_ff;
      count_in      = count_ff;
      result.done   = 1'b0;
      result.status = RX_STATUS_BYTE;
      result.data   = '0;

      unique case (phase)
         PH_WAIT_HIGH, PH_WAIT_LOW: begin
            if ((phase == PH_WAIT_HIGH && line) || (phase == PH_WAIT_LOW && !line)) begin
               phase_in = (phase == PH_WAIT_HIGH) ? PH_WAIT_LOW : PH_START;
               timer_in = '0;
            end else if (!no_limit) begin
               elapsed_in = elapsed_inc;
               if (limit_hit) begin
                  phase_in      = PH_IDLE;
                  result.done   = 1'b1;
                  result.status = RX_STATUS_TIMEOUT;
               end
            end
         end
         PH_START: begin
            timer_in = timer_inc[PERIOD_W-1:0];
            if (timer_inc >= half_period) begin
               if (line) begin
                  phase_in      = PH_IDLE;
                  result.done   = 1'b1;
                  result.status = RX_STATUS_FALSE;
               end else begin
                  phase_in = PH_DATA;
                  timer_in = '0;
                  shift_in = '0;
                  count_in = 4'd0;
               end
            end
         end
         PH_DATA: begin
            timer_in = timer_inc[PERIOD_W-1:0];
            if (timer_inc >= {1'b0, period}) begin
               timer_in = '0;
               shift_in = {line, shift_ff[DATA_W-1:1]};
               count_in = count_inc;
               if (count_inc >= 4'd8) begin
                  phase_in = PH_STOP;
               end
            end
         end
         PH_STOP: begin
            timer_in = timer_inc[PERIOD_W-1:0];
            if (timer_inc >= {1'b0, period}) begin
               timer_in    = '0;
               phase_in    = PH_IDLE;
               result.done = 1'b1;
               result.data = shift_ff;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      result.busy = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         timer_ff   <= '0;
         elapsed_ff <= '0;
         limit_ff   <= '0;
         shift_ff   <= '0;
         count_ff   <= 4'd0;
      end else if (step) begin
         phase_ff   <= phase_in;
         timer_ff   <= timer_in;
         elapsed_ff <= elapsed_in;
         limit_ff   <= limit_in;
         shift_ff   <= shift_in;
         count_ff   <= count_in;
      end
   end

endmodule

[sv/uart_8n1_transceiver_with_timeout.sv]
// UART transceiver, 8 data bits, no parity, one stop bit. Each transaction on
// the req_ side is one microsecond tick carrying the sampled receive line and
// the transmit and receive requests; it yields exactly one response
// transaction with the transmit line level and the receive status for that
// tick. A tick is taken in every cycle in which req_tready is high, and its
// response appears in the output register on the next cycle; a single output
// register lets a new tick enter while the previous response is still being
// taken, so the sustained rate is one tick per cycle whenever rsp_tready is
// high. The bit period register (csr_) holds ticks per bit, 104 after reset,
// and values below 8 act as 8. It must only be written while no tick is in flight.
module uart_8n1_transceiver_with_timeout
   import uart_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // rx_line[0], tx_start[1], tx_data[9:2], rx_arm[10], rx_timeout_ms[26:11], zero pad
   input  logic [31:0]         req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // tx_line[0], tx_busy[1], rx_busy[2], rx_done[3], rx_status[5:4], rx_byte[13:6],
   // zero pad
   output logic [15:0]         rsp_tdata,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [PERIOD_W-1:0] csr_data
);

   logic [PERIOD_W-1:0] period_ff;
   logic [PERIOD_W-1:0] period;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [15:0]         rsp_data_ff, rsp_data_in;
   logic                step;
   logic                tx_line;
   logic                tx_busy;
   rx_result_type       rx_result;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;
   assign period     = (period_ff < PERIOD_MIN) ? PERIOD_MIN : period_ff;

   uart_tx_core u_tx (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .start   (req_tdata[1]),
      .data    (req_tdata[9:2]),
      .period  (period),
      .tx_line (tx_line),
      .tx_busy (tx_busy)
   );

   uart_rx_core u_rx (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .line     (req_tdata[0]),
      .arm      (req_tdata[10]),
      .limit_ms (req_tdata[26:11]),
      .period   (period),
      .result   (rx_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {2'b00, rx_result.data, rx_result.status, rx_result.done,
                         rx_result.busy, tx_busy, tx_line};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= PERIOD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            period_ff <= csr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[tb/uart_8n1_transceiver_with_timeout_checker.sv]
module uart_8n1_transceiver_with_timeout_checker
   import uart_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [31:0]         req_tdata,
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [15:0]         rsp_tdata,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [PERIOD_W-1:0] csr_data,
   output int                  fail_count,
   output int                  pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [2:0] {
      RX_IDLE, RX_WAIT_HIGH, RX_WAIT_LOW, RX_START, RX_DATA, RX_STOP
   } rx_state_type;

   typedef struct packed {
      logic          tx_line;
      logic          tx_busy;
      rx_result_type rx;
   } tick_result_type;

   // Model state of the transceiver.
   logic [PERIOD_W-1:0]  period_reg = PERIOD_RESET;
   logic                 tx_on      = 1'b0;
   logic [3:0]           tx_bits    = '0;
   logic [DATA_W-1:0]    tx_data_sr = '0;
   logic [PERIOD_W-1:0]  tx_count   = '0;
   rx_state_type         rx_state   = RX_IDLE;
   logic [PERIOD_W-1:0]  rx_count   = '0;
   logic [ELAPSED_W-1:0] rx_waited  = '0;
   logic [TIMEOUT_W-1:0] rx_limit   = '0;
   logic [DATA_W-1:0]    rx_data_sr = '0;
   logic [3:0]           rx_bits    = '0;

   tick_result_type expected_ticks [$];
   int              response_index = 0;

   initial begin
      fail_count = 0;
      pending = 0;
   end

   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      if (fail_count < 50)
         $display("[%0t] response %0d: %s expected 0x%0h, got 0x%0h",
                  $realtime, response_index, what, want, got);
      fail_count++;
   endtask

   // Advances the model by one microsecond tick and returns its response.
   function automatic tick_result_type uart_tick(input logic [31:0] word);
      logic                line;
      logic                start;
      logic [DATA_W-1:0]   data;
      logic                arm;
      logic [TIMEOUT_W-1:0] tmo;
      logic [PERIOD_W-1:0] p;
      tick_result_type     r;
      line  = word[0];
      start = word[1];
      data  = word[9:2];
      arm   = word[10];
      tmo   = word[26:11];
      p = (period_reg < PERIOD_MIN) ? PERIOD_MIN : period_reg;
      r = '0;
      r.tx_line = 1'b1;

      if (!tx_on && start) begin
         tx_on      = 1'b1;
         tx_bits    = '0;
         tx_data_sr = data;
         tx_count   = '0;
      end
      r.tx_busy = tx_on;
      if (tx_on) begin
         if (tx_bits == 0)
            r.tx_line = 1'b0;
         else if (tx_bits <= 8)
            r.tx_line = tx_data_sr[0];
         else
            r.tx_line = 1'b1;
         if (32'(tx_count) + 1 >= 32'(p)) begin
            tx_count = '0;
            if (tx_bits >= 1 && tx_bits <= 8)
               tx_data_sr = tx_data_sr >> 1;
            if (tx_bits >= 9) begin
               tx_on   = 1'b0;
               tx_bits = '0;
            end else begin
               tx_bits++;
            end
         end else begin
            tx_count++;
         end
      end

      if (rx_state == RX_IDLE && arm) begin
         rx_state  = RX_WAIT_HIGH;
         rx_limit  = tmo;
         rx_waited = '0;
      end
      case (rx_state)
         RX_WAIT_HIGH, RX_WAIT_LOW: begin
            if ((rx_state == RX_WAIT_HIGH && line) || (rx_state == RX_WAIT_LOW && !line)) begin
               rx_state = (rx_state == RX_WAIT_HIGH) ? RX_WAIT_LOW : RX_START;
               rx_count = '0;
            end else if (rx_limit != 0) begin
               // A zero limit waits forever and never counts.
               rx_waited++;
               if (32'(rx_waited) >= 32'(rx_limit) * 32'(US_PER_MS)) begin
                  rx_state    = RX_IDLE;
                  r.rx.done   = 1'b1;
                  r.rx.status = RX_STATUS_TIMEOUT;
               end
            end
         end
         RX_START: begin
            rx_count++;
            if (rx_count >= (p >> 1)) begin
               if (line) begin
                  rx_state    = RX_IDLE;
                  r.rx.done   = 1'b1;
                  r.rx.status = RX_STATUS_FALSE;
               end else begin
                  rx_state   = RX_DATA;
                  rx_count   = '0;
                  rx_data_sr = '0;
                  rx_bits    = '0;
               end
            end
         end
         RX_DATA: begin
            rx_count++;
            if (rx_count >= p) begin
               rx_count   = '0;
               rx_data_sr = {line, rx_data_sr[7:1]};
               rx_bits++;
               if (rx_bits >= 8)
                  rx_state = RX_STOP;
            end
         end
         RX_STOP: begin
            rx_count++;
            if (rx_count >= p) begin
               rx_count    = '0;
               rx_state    = RX_IDLE;
               r.rx.done   = 1'b1;
               r.rx.status = RX_STATUS_BYTE;
               r.rx.data   = rx_data_sr;
            end
         end
         default: begin
            rx_state = RX_IDLE;
         end
      endcase
      r.rx.busy = (rx_state != RX_IDLE);
      return r;
   endfunction

   always @(posedge clock) begin
      tick_result_type got;
      tick_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.tx_line   = rsp_tdata[0];
            got.tx_busy   = rsp_tdata[1];
            got.rx.busy   = rsp_tdata[2];
            got.rx.done   = rsp_tdata[3];
            got.rx.status = rsp_tdata[5:4];
            got.rx.data   = rsp_tdata[13:6];
            if (expected_ticks.size() == 0) begin
               report_mismatch("unexpected response, tdata", 0, rsp_tdata);
            end else begin
               want = expected_ticks.pop_front();
               if (got.tx_line !== want.tx_line)
                  report_mismatch("tx_line", want.tx_line, got.tx_line);
               if (got.tx_busy !== want.tx_busy)
                  report_mismatch("tx_busy", want.tx_busy, got.tx_busy);
               if (got.rx.busy !== want.rx.busy)
                  report_mismatch("rx_busy", want.rx.busy, got.rx.busy);
               if (got.rx.done !== want.rx.done)
                  report_mismatch("rx_done", want.rx.done, got.rx.done);
               if (got.rx.status !== want.rx.status)
                  report_mismatch("rx_status", want.rx.status, got.rx.status);
               if (got.rx.data !== want.rx.data)
                  report_mismatch("rx_byte", want.rx.data, got.rx.data);
               if (rsp_tdata[15:14] !== 2'b00)
                  report_mismatch("padding", 0, rsp_tdata[15:14]);
            end
            response_index++;
         end
         // A tick taken at the same edge as a register write still sees the old period.
         if (req_tvalid && req_tready)
            expected_ticks.push_back(uart_tick(req_tdata));
         if (csr_valid && csr_ready)
            period_reg = csr_data;
      end
      pending <= expected_ticks.size();
   end

endmodule

[tb/uart_8n1_transceiver_with_timeout_tb.sv]
module uart_8n1_transceiver_with_timeout_tb;
   import uart_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [31:0]         req_tdata  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [15:0]         rsp_tdata;
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   logic [PERIOD_W-1:0] csr_data   = '0;

   int fail_count;
   int pending;
   int cycles = 0;

   // Stimulus state: the planned receive line waveform and the bit period it uses.
   logic line_plan [$];
   int   line_period = 104;
   logic calm = 1'b0;

   logic [PERIOD_W-1:0] phase_period [4] = '{20'd16, 20'hFFFFF, 20'd9, 20'd8};
   int                  phase_items  [4] = '{220, 30, 230, 230};

   uart_8n1_transceiver_with_timeout DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   uart_8n1_transceiver_with_timeout_checker scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // Response backpressure in random bursts, none in the closing stretch.
   initial begin
      @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   task automatic send_tick(input logic line, input logic start, input logic [7:0] data,
                            input logic arm, input logic [15:0] tmo);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, tmo, arm, data, start, line};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_bit_period(input logic [PERIOD_W-1:0] value);
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      line_period = (value < PERIOD_MIN) ? int'(PERIOD_MIN) : int'(value);
   endtask

   // Appends one segment to the receive line: mostly whole frames, some idle,
   // glitches under half a bit, breaks, noise; only noise for a period over 64.
   task automatic plan_line_segment();
      int         p;
      int         pick;
      logic [7:0] frame_byte;
      p = line_period;
      pick = $urandom_range(0, 19);
      if (p > 64)
         pick = 19;
      if (pick < 12) begin
         frame_byte = 8'($urandom);
         repeat (p) line_plan.push_back(1'b0);
         for (int i = 0; i < 8; i++)
            repeat (p) line_plan.push_back(frame_byte[i]);
         repeat ($urandom_range(p, 3 * p)) line_plan.push_back(1'b1);
      end else if (pick < 15) begin
         repeat ($urandom_range(1, 3 * p)) line_plan.push_back(1'b1);
      end else if (pick < 17) begin
         repeat ($urandom_range(1, p / 2 - 1)) line_plan.push_back(1'b0);
         repeat (p) line_plan.push_back(1'b1);
      end else if (pick < 18) begin
         repeat ($urandom_range(2 * p, 12 * p)) line_plan.push_back(1'b0);
      end else begin
         repeat ($urandom_range(1, 20)) line_plan.push_back(1'($urandom_range(0, 1)));
      end
   endtask

   task automatic random_tick();
      logic        line;
      logic [15:0] tmo;
      if (line_plan.size() == 0)
         plan_line_segment();
      line = line_plan.pop_front();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: tmo = 16'd0;
         4:          tmo = 16'd1;
         default:    tmo = 16'($urandom);
      endcase
      send_tick(line, $urandom_range(0, 7) == 0, 8'($urandom), $urandom_range(0, 3) == 0, tmo);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // A period below the minimum behaves as the minimum of eight ticks.
      write_bit_period('0);
      send_tick(1'b1, 1'b1, 8'h00, 1'b1, 16'hFFFF);
      // Both sides are busy now, so these requests are ignored.
      send_tick(1'b1, 1'b1, 8'hFF, 1'b1, 16'h0000);
      send_tick(1'b0, 1'b0, 8'h00, 1'b0, 16'h0000);
      repeat (3) send_tick(1'b0, 1'b0, 8'h00, 1'b0, 16'h0000);
      // Line back high at the middle of the start bit: false start.
      send_tick(1'b1, 1'b0, 8'h00, 1'b0, 16'h0000);
      // Zero timeout waits without counting while the line stays low.
      send_tick(1'b0, 1'b0, 8'h00, 1'b1, 16'h0000);
      send_tick(1'b0, 1'b0, 8'h00, 1'b0, 16'h0000);
      send_tick(1'b1, 1'b0, 8'h00, 1'b0, 16'h0000);
      send_tick(1'b0, 1'b0, 8'h00, 1'b0, 16'h0000);
      repeat (4) send_tick(1'b0, 1'b0, 8'h00, 1'b0, 16'h0000);
      repeat (8) send_tick(1'b1, 1'b0, 8'h00, 1'b0, 16'h0000);
      wait_for_drain();

      // The transmit frame and the reception are still running across this write.
      write_bit_period(20'd13);
      repeat (150) send_tick(1'b1, $urandom_range(0, 7) == 0, 8'($urandom), 1'b0, 16'h0000);
      wait_for_drain();

      for (int ph = 0; ph < 4; ph++) begin
         write_bit_period(phase_period[ph]);
         for (int n = 0; n < phase_items[ph]; n++) begin
            if (ph == 3 && n >= 160)
               calm = 1'b1;
            random_tick();
         end
         wait_for_drain();
      end

      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
